// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros used by the bae_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg
// shared constants and types for the bounded array engine
// ----------------------------------------------------------------------------
`default_nettype none
package bae_pkg;
  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = AW + 1;
  localparam int unsigned OUT_BITS  = 38;

  typedef logic [3:0]          kind_t;
  typedef logic [2:0]          status_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam kind_t K_APPEND = 4'd0;
  localparam kind_t K_INSERT = 4'd1;
  localparam kind_t K_DELETE = 4'd2;
  localparam kind_t K_LSRCH  = 4'd3;
  localparam kind_t K_BSRCH  = 4'd4;
  localparam kind_t K_MAX    = 4'd5;
  localparam kind_t K_MIN    = 4'd6;
  localparam kind_t K_SUM    = 4'd7;
  localparam kind_t K_REV    = 4'd8;
  localparam kind_t K_CLEAR  = 4'd9;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_BAD_POS   = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;
endpackage
`default_nettype wire

// ===== hw/rtl/bae_if.sv =====
// ----------------------------------------------------------------------------
// bae channel interfaces
// valid/ready channels for operations, results and configuration
// ----------------------------------------------------------------------------
`default_nettype none
interface bae_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [5:0] position;
  logic signed [31:0] word_in;
  modport source (output valid, kind, position, word_in, input ready);
  modport sink   (input valid, kind, position, word_in, output ready);
endinterface

interface bae_out_if;
  logic       valid;
  logic       ready;
  logic signed [37:0] word_out;
  logic [5:0] found_at;
  logic [2:0] status;
  logic [6:0] count_now;
  modport source (output valid, word_out, found_at, status, count_now, input ready);
  modport sink   (input valid, word_out, found_at, status, count_now, output ready);
endinterface

interface bae_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bae_ram.sv =====
// ----------------------------------------------------------------------------
// bae_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module bae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write when enabled, and registered read of the old contents every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bounded_array_engine_core.sv =====
// ----------------------------------------------------------------------------
// bounded_array_engine_core
// packed signed word array with insert/delete/search/reduce operations
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one operation per transaction (kind, position, word_in)
//  out_* : one result per operation (word_out, found_at, status, count_now)
//  cfg_* : writes capacity; write only while the engine is idle
//  One memory port does all work. Each entry visit walks the address, read
//  wait and use states. Rejects, an empty array, clear and unused kinds touch
//  no entry; append writes one entry, insert shifts the entries from pos up,
//  delete reads the word at pos and shifts the entries above it down, linear
//  search/max/min/sum scan the entries in order, binary search makes at most 7
//  probes, and reverse swaps pairs from both ends. Worst case is a 64 entry
//  reverse.
//  in_ready is high only while idle; the result sits in an output register
//  until taken, and a stalled receiver holds the engine in that state. Once
//  the result is taken, a new operation can be accepted from the next cycle.
//  Reset clears count and sets capacity to 64; array contents stay as they are.
// ----------------------------------------------------------------------------
`default_nettype none
module bounded_array_engine_core (
  input wire logic clk,
  input wire logic rst_n,
  bae_in_if.sink   in_ch,
  bae_out_if.source out_ch,
  bae_cfg_if.sink  cfg_ch
);
  import bae_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_USE, S_WR_B, S_DONE
  } state_t;

  localparam logic signed [CW:0] ONE_S = {{CW{1'b0}}, 1'b1};

  state_t  state_r, state_nxt;
  kind_t   kind_r, kind_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  word_t   key_r, key_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] i_r, i_nxt;        // walk index
  logic [CW-1:0] j_r, j_nxt;        // reverse high index
  logic signed [CW:0] lo_r, lo_nxt;
  logic signed [CW:0] hi_r, hi_nxt;
  logic signed [OUT_BITS-1:0] acc_r, acc_nxt;
  logic [AW-1:0] found_r, found_nxt;
  status_t st_r, st_nxt;
  word_t   tmp_r, tmp_nxt;
  logic    phase_r, phase_nxt;
  logic    out_v_r, out_v_nxt;

  logic          we;
  logic [AW-1:0] addr;
  word_t         wdata, rdata;
  logic signed [OUT_BITS-1:0] rd_ext;

  bae_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rd_ext = OUT_BITS'($signed(rdata));

  logic [CW-1:0] room;
  assign room = (cap_r > CW'(DEPTH)) ? CW'(DEPTH) : cap_r;

  logic signed [CW:0] mid;
  assign mid = (lo_r + hi_r) >>> 1;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.word_out  = acc_r;
  assign out_ch.found_at  = found_r;
  assign out_ch.status    = st_r;
  assign out_ch.count_now = count_r;

  // memory access control, read address held through the read latency
  always_comb begin
    we = 1'b0; addr = i_r[AW-1:0]; wdata = tmp_r;
    case (state_r)
      S_RD, S_WAIT: begin
        if (kind_r == K_BSRCH) addr = mid[AW-1:0];
        else if (kind_r == K_REV && phase_r) addr = j_r[AW-1:0];
        else if (kind_r == K_INSERT) addr = AW'(i_r - 1'b1);
        else if (kind_r == K_DELETE && !phase_r) addr = AW'(i_r + 1'b1);
      end
      S_USE: begin
        case (kind_r)
          K_INSERT: begin we = 1'b1; wdata = rdata; end
          K_DELETE: if (!phase_r) begin we = 1'b1; wdata = rdata; end
          K_REV: if (phase_r) begin we = 1'b1; wdata = rdata; end
          default: ;
        endcase
      end
      S_WR_B: begin
        we = 1'b1;
        if (kind_r == K_REV) addr = j_r[AW-1:0];
        else begin addr = pos_r; wdata = key_r; end
        if (kind_r == K_APPEND) addr = count_r[AW-1:0];
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r; kind_nxt = kind_r; pos_nxt = pos_r; key_nxt = key_r;
    count_nxt = count_r; cap_nxt = cap_r; i_nxt = i_r; j_nxt = j_r;
    lo_nxt = lo_r; hi_nxt = hi_r; acc_nxt = acc_r; found_nxt = found_r;
    st_nxt = st_r; tmp_nxt = tmp_r; phase_nxt = phase_r; out_v_nxt = out_v_r;
    if (cfg_ch.valid) cap_nxt = cfg_ch.data;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        kind_nxt = in_ch.kind; pos_nxt = in_ch.position;
        key_nxt = in_ch.word_in; acc_nxt = '0; found_nxt = '0; st_nxt = ST_OK;
        phase_nxt = 1'b0;
        state_nxt = S_DONE;
        case (in_ch.kind)
          K_APPEND: if (count_r >= room) st_nxt = ST_FULL;
                    else state_nxt = S_WR_B;
          K_INSERT: if (count_r >= room) st_nxt = ST_FULL;
                    else if (CW'(in_ch.position) > count_r) st_nxt = ST_BAD_POS;
                    else if (CW'(in_ch.position) == count_r) state_nxt = S_WR_B;
                    else begin i_nxt = count_r; state_nxt = S_RD; end
          K_DELETE: if (count_r == '0) st_nxt = ST_EMPTY;
                    else if (CW'(in_ch.position) >= count_r) st_nxt = ST_BAD_POS;
                    else begin
                      i_nxt = CW'(in_ch.position); phase_nxt = 1'b1; state_nxt = S_RD;
                    end
          K_LSRCH, K_SUM: begin
            if (in_ch.kind == K_LSRCH) st_nxt = ST_NOT_FOUND;
            i_nxt = '0;
            if (count_r != '0) state_nxt = S_RD;
          end
          K_BSRCH: begin
            st_nxt = ST_NOT_FOUND; lo_nxt = '0;
            hi_nxt = $signed({1'b0, count_r}) - ONE_S;
            if (count_r != '0) state_nxt = S_RD;
          end
          K_MAX, K_MIN: if (count_r == '0) st_nxt = ST_EMPTY;
                        else begin i_nxt = '0; state_nxt = S_RD; end
          K_REV: if (count_r > CW'(1)) begin
            i_nxt = '0; j_nxt = count_r - 1'b1; state_nxt = S_RD;
          end
          K_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
      S_RD: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_USE;
      S_USE: begin
        state_nxt = S_RD;
        case (kind_r)
          K_INSERT: begin
            i_nxt = i_r - 1'b1;
            if (i_r - 1'b1 == CW'(pos_r)) state_nxt = S_WR_B;
          end
          K_DELETE: begin
            if (phase_r) begin
              acc_nxt = rd_ext; phase_nxt = 1'b0;
              if (i_r + 1'b1 >= count_r) begin
                count_nxt = count_r - 1'b1; state_nxt = S_DONE;
              end
            end else begin
              i_nxt = i_r + 1'b1;
              if (i_r + 2'd2 >= count_r) begin
                count_nxt = count_r - 1'b1; state_nxt = S_DONE;
              end
            end
          end
          K_LSRCH: if ($signed(rdata) == $signed(key_r)) begin
              st_nxt = ST_OK; found_nxt = i_r[AW-1:0]; state_nxt = S_DONE;
            end else begin
              i_nxt = i_r + 1'b1;
              if (i_r + 1'b1 >= count_r) state_nxt = S_DONE;
            end
          K_SUM: begin
            acc_nxt = acc_r + rd_ext;
            i_nxt = i_r + 1'b1;
            if (i_r + 1'b1 >= count_r) state_nxt = S_DONE;
          end
          K_MAX, K_MIN: begin
            if (i_r == '0 ||
                (kind_r == K_MAX && rd_ext > acc_r) ||
                (kind_r == K_MIN && rd_ext < acc_r))
              acc_nxt = rd_ext;
            i_nxt = i_r + 1'b1;
            if (i_r + 1'b1 >= count_r) state_nxt = S_DONE;
          end
          K_BSRCH: begin
            if ($signed(rdata) == $signed(key_r)) begin
              st_nxt = ST_OK; found_nxt = mid[AW-1:0]; state_nxt = S_DONE;
            end else if ($signed(key_r) < $signed(rdata)) begin
              hi_nxt = mid - ONE_S;
              if (lo_r > mid - ONE_S) state_nxt = S_DONE;
            end else begin
              lo_nxt = mid + ONE_S;
              if (mid + ONE_S > hi_r) state_nxt = S_DONE;
            end
          end
          K_REV: begin
            if (!phase_r) begin
              tmp_nxt = rdata; phase_nxt = 1'b1;   // hold low word, read high
            end else begin
              state_nxt = S_WR_B;                  // low written, now high
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_WR_B: begin
        state_nxt = S_DONE;
        if (kind_r == K_APPEND || kind_r == K_INSERT) count_nxt = count_r + 1'b1;
        if (kind_r == K_REV) begin
          phase_nxt = 1'b0; i_nxt = i_r + 1'b1; j_nxt = j_r - 1'b1;
          if (i_r + 1'b1 < j_r - 1'b1) state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_v_r) out_v_nxt = 1'b1;
        else if (out_ch.ready) begin out_v_nxt = 1'b0; state_nxt = S_IDLE; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; cap_r <= CW'(DEPTH); out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; cap_r <= cap_nxt;
      out_v_r <= out_v_nxt;
    end
    kind_r <= kind_nxt; pos_r <= pos_nxt; key_r <= key_nxt;
    i_r <= i_nxt; j_r <= j_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    acc_r <= acc_nxt; found_r <= found_nxt; st_r <= st_nxt;
    tmp_r <= tmp_nxt; phase_r <= phase_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bae_checker.sv =====
// ----------------------------------------------------------------------------
// bae_checker
// port-level checks of the engine handshakes
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bae_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] out_status,
  input wire logic [6:0] out_count_now
);
  import bae_pkg::*;

  // no new operation taken while a result is pending
  `CHK_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "accept while result pending")
  // an accepted operation blocks further input next cycle
  `CHK_NEXT(a_busy_after, clk, rst_n, in_valid && in_ready, !in_ready, "not busy after accept")
  // count never exceeds storage
  `CHK_IMPL(a_count, clk, rst_n, out_valid, out_count_now <= 7'(DEPTH), "count beyond depth")
  // result held while stalled
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status),
            "result dropped")
endmodule

bind bounded_array_engine_core bae_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_count_now(out_ch.count_now)
);
`default_nettype wire

// ===== bench/bae_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_tb_pkg
// array state predictor and result scoreboard for the bounded array engine
// ----------------------------------------------------------------------------
package bae_tb_pkg;
  import bae_pkg::*;

  typedef struct packed {
    logic signed [37:0] word_out;
    logic [5:0]         found_at;
    status_t            status;
    logic [6:0]         count_now;
  } result_t;

  class array_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int unsigned        length;
    int unsigned        capacity;
    result_t            pending [$];
    int unsigned        mismatches;

    function new();
      length = 0;
      capacity = 64;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_capacity(logic [6:0] value);
      capacity = value;
    endfunction

    // apply one accepted operation and queue the expected result
    function void note_operation(kind_t kind, logic [5:0] pos, logic signed [31:0] w);
      result_t r;
      int unsigned room_left;
      int lo, hi, mid;
      logic signed [63:0] acc;
      logic signed [31:0] t;
      r = '0;
      r.status = ST_OK;
      room_left = (capacity > DEPTH) ? DEPTH : capacity;
      acc = 0;
      case (kind)
        K_APPEND: begin
          if (length >= room_left) r.status = ST_FULL;
          else begin
            slots[length] = w;
            length++;
          end
        end
        K_INSERT: begin
          if (length >= room_left) r.status = ST_FULL;
          else if (pos > length) r.status = ST_BAD_POS;
          else begin
            for (int i = length; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = w;
            length++;
          end
        end
        K_DELETE: begin
          if (length == 0) r.status = ST_EMPTY;
          else if (pos >= length) r.status = ST_BAD_POS;
          else begin
            r.word_out = slots[pos];
            for (int i = pos; i + 1 < length; i++) slots[i] = slots[i+1];
            length--;
          end
        end
        K_LSRCH: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < length; i++)
            if (slots[i] == w) begin
              r.found_at = 6'(i);
              r.status = ST_OK;
              break;
            end
        end
        K_BSRCH: begin
          lo = 0;
          hi = int'(length) - 1;
          r.status = ST_NOT_FOUND;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (w == slots[mid]) begin
              r.found_at = 6'(mid);
              r.status = ST_OK;
              break;
            end else if (w < slots[mid]) hi = mid - 1;
            else lo = mid + 1;
          end
        end
        K_MAX, K_MIN: begin
          if (length == 0) r.status = ST_EMPTY;
          else begin
            t = slots[0];
            for (int i = 1; i < length; i++)
              if (kind == K_MAX ? slots[i] > t : slots[i] < t) t = slots[i];
            r.word_out = t;
          end
        end
        K_SUM: begin
          for (int i = 0; i < length; i++) acc += slots[i];
          r.word_out = 38'(acc);
        end
        K_REV: begin
          for (int i = 0; i < length / 2; i++) begin
            t = slots[i];
            slots[i] = slots[length-1-i];
            slots[length-1-i] = t;
          end
        end
        K_CLEAR: length = 0;
        default: ;
      endcase
      r.count_now = 7'(length);
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass
endpackage

// ===== bench/bounded_array_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_array_engine_core_tb
// directed and random array operations under bursty input and receiver
// stalls, each result checked against a scoreboard model of the array
// ----------------------------------------------------------------------------
module bounded_array_engine_core_tb;
  import bae_pkg::*;
  import bae_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic out_ready_q = 1'b0;

  bae_in_if  in_ch ();
  bae_out_if out_ch ();
  bae_cfg_if cfg_ch ();

  array_scoreboard board;
  int unsigned idle_cycles;
  int unsigned stall_mode;
  int unsigned shadow_len;
  int unsigned shadow_room;

  bounded_array_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  assign out_ch.ready = out_ready_q;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.position = '0;
    in_ch.word_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    board = new();
    stall_mode = 0;
  end

  // receiver stall pattern, changing style now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_q <= 1'b1;
      1: out_ready_q <= ($urandom_range(0, 3) != 0);
      2: out_ready_q <= ($urandom_range(0, 3) == 0);
      default: out_ready_q <= ~out_ready_q;
    endcase
  end

  // result checking and stall watchdog
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else begin
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.word_out, out_ch.found_at, out_ch.status,
                            out_ch.count_now});
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // send one operation transaction and predict it
  task automatic send_op(kind_t kind, logic [5:0] pos, logic signed [31:0] w);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.position <= pos;
    in_ch.word_in <= w;
    do @(posedge clk); while (!in_ch.ready);
    board.note_operation(kind, pos, w);
    shadow_len = board.length;
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // wait for the engine to drain, then write the capacity register
  task automatic write_capacity(logic [6:0] value);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_capacity(value);
    shadow_room = (value > DEPTH) ? DEPTH : value;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // one random operation, leaning on well-formed positions
  task automatic random_op(bit sorted_mode);
    kind_t k;
    logic [5:0] p;
    logic signed [31:0] w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) k = K_APPEND;
    else if (r < 45) k = K_INSERT;
    else if (r < 60) k = K_DELETE;
    else if (r < 68) k = K_LSRCH;
    else if (r < 76) k = K_BSRCH;
    else if (r < 81) k = K_MAX;
    else if (r < 86) k = K_MIN;
    else if (r < 91) k = K_SUM;
    else if (r < 95) k = K_REV;
    else if (r < 97) k = K_CLEAR;
    else k = kind_t'($urandom_range(10, 15));
    if ($urandom_range(0, 9) == 0) p = $urandom;
    else p = $urandom_range(0, shadow_len);
    w = rand_word();
    // searches mostly look for stored keys
    if ((k == K_LSRCH || k == K_BSRCH) && shadow_len > 0 && $urandom_range(0, 2) != 0)
      w = board.slots[$urandom_range(0, shadow_len - 1)];
    // sorted phase: append non-decreasing values so binary search is meaningful
    if (sorted_mode && k == K_APPEND)
      w = (shadow_len == 0) ? $signed(-32'sd1000) : board.slots[shadow_len-1] + $urandom_range(0, 3);
    if (sorted_mode && (k == K_INSERT || k == K_REV)) k = K_LSRCH;
    send_op(k, p, w);
  endtask

  task automatic random_phase(int unsigned n, bit sorted_mode);
    int unsigned burst;
    int unsigned done;
    done = 0;
    while (done < n) begin
      burst = $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst && done < n; i++) begin
        random_op(sorted_mode);
        done++;
      end
      if ($urandom_range(0, 2) != 0) pause_input();
    end
  endtask

  initial begin
    shadow_len = 0;
    shadow_room = DEPTH;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-array cases
    send_op(K_DELETE, 6'd0, 0);
    send_op(K_MAX, 6'd0, 0);
    send_op(K_MIN, 6'd0, 0);
    send_op(K_SUM, 6'd0, 0);
    send_op(K_LSRCH, 6'd0, 32'sd5);
    send_op(K_BSRCH, 6'd0, 32'sd5);
    send_op(K_REV, 6'd0, 0);
    // extremes of the word and positions
    send_op(K_APPEND, 6'd0, 32'sh80000000);
    send_op(K_APPEND, 6'd63, 32'sh7fffffff);
    send_op(K_INSERT, 6'd1, -32'sd1);
    send_op(K_INSERT, 6'd63, 32'sd1);
    send_op(K_MAX, 6'd0, 0);
    send_op(K_MIN, 6'd0, 0);
    send_op(K_SUM, 6'd0, 0);
    send_op(K_REV, 6'd0, 0);
    send_op(K_LSRCH, 6'd0, -32'sd1);
    send_op(K_DELETE, 6'd63, 0);
    send_op(K_DELETE, 6'd2, 0);
    send_op(kind_t'(4'd15), 6'd63, 32'sh7fffffff);
    send_op(kind_t'(4'd10), 6'd0, 0);
    send_op(K_CLEAR, 6'd0, 0);

    // small capacity: full array cases
    write_capacity(7'd1);
    send_op(K_APPEND, 6'd0, 32'sd3);
    send_op(K_APPEND, 6'd0, 32'sd4);
    send_op(K_INSERT, 6'd0, 32'sd4);
    random_phase(150, 1'b0);

    // zero capacity, with entries kept above it
    write_capacity(7'd0);
    random_phase(100, 1'b0);

    // capacity beyond storage, fill to full
    write_capacity(7'd127);
    for (int i = 0; i < 66; i++) send_op(K_APPEND, 6'd0, $urandom);
    send_op(K_INSERT, 6'd0, 0);
    send_op(K_SUM, 6'd0, 0);
    send_op(K_REV, 6'd0, 0);
    send_op(K_DELETE, 6'd63, 0);
    send_op(K_INSERT, 6'd63, 0);
    random_phase(500, 1'b0);

    write_capacity(7'd8);
    random_phase(300, 1'b0);

    // sorted contents for binary search
    write_capacity(7'd64);
    send_op(K_CLEAR, 6'd0, 0);
    random_phase(400, 1'b1);

    write_capacity(7'd64);
    random_phase(550, 1'b0);

    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bae_pkg.sv
hw/rtl/bae_if.sv
hw/rtl/bae_ram.sv
hw/rtl/bounded_array_engine_core.sv
hw/rtl/bae_checker.sv
bench/bae_tb_pkg.sv
bench/bounded_array_engine_core_tb.sv
